### hdl/assert_macros.svh
// Assertion helpers included by the top-level decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of aclk while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every rising edge of aclk, reset cycles included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/ps2md_pkg.sv
`default_nettype none

package ps2md_pkg;

    localparam int BYTE_W = 8;
    localparam int TDATA_W = 32;

    // Header bit positions.
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int BTN_W = 3;

    typedef logic [1:0] byte_cnt_t;

    // Count value at which the arriving word closes a packet.
    localparam byte_cnt_t LAST_IDX_STD   = 2'd2;
    localparam byte_cnt_t LAST_IDX_WHEEL = 2'd3;

    typedef struct packed {
        logic                has_wheel;
        logic [BTN_W-1:0]    button_bits;
        logic signed [7:0]   delta_wheel;
        logic signed [9:0]   delta_y;
        logic signed [8:0]   delta_x;
    } result_t;

endpackage

`default_nettype wire

### hdl/ps2md_frame.sv
`default_nettype none

module ps2md_frame (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    advance,
    input  wire logic                    wheel_mode,
    output      logic                    complete,
    output      ps2md_pkg::result_t      result
);
    import ps2md_pkg::*;

    byte_cnt_t        count_reg;
    byte_cnt_t        count_next;
    logic [BYTE_W-1:0] pkt_reg [3];
    byte_cnt_t        last_idx;
    logic             drop;
    logic             closes;
    logic [BYTE_W-1:0] byte2;
    logic [9:0]       y_ext;

    assign last_idx = wheel_mode ? LAST_IDX_WHEEL : LAST_IDX_STD;
    // A first word without the sync bit is not a header and is thrown away.
    assign drop     = (count_reg == 2'd0) && !in_byte[HDR_SYNC_BIT];
    assign closes   = (count_reg >= last_idx);
    assign complete = in_valid && !drop && closes;

    always_comb begin
        count_next = count_reg;
        if (in_valid && advance && !drop) begin
            if (closes) begin
                count_next = 2'd0;
            end else begin
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        if (in_valid && advance && !drop && !closes) begin
            pkt_reg[count_reg] <= in_byte;
        end
    end

    // The third byte is the live word when a standard packet closes.
    assign byte2 = (count_reg == 2'd2) ? in_byte : pkt_reg[2];
    assign y_ext = {{2{pkt_reg[0][HDR_YSIGN_BIT]}}, byte2};

    always_comb begin
        result.delta_x     = {pkt_reg[0][HDR_XSIGN_BIT], pkt_reg[1]};
        result.delta_y     = 10'd0 - y_ext;
        result.delta_wheel = wheel_mode ? in_byte : 8'd0;
        result.button_bits = pkt_reg[0][BTN_W-1:0];
        result.has_wheel   = wheel_mode;
    end

endmodule

`default_nettype wire

### hdl/ps2_mouse_packet_decoder.sv
`default_nettype none

// PS/2 mouse packet decoder. Raw mouse-port bytes enter on the s_ stream one
// word at a time; a first byte must carry header bit 3 or it is discarded.
// Three bytes (or four when wheel_mode is set through the cfg_ port) form a
// packet, which leaves on the m_ stream as one decoded word: 9-bit X, Y
// negated to screen direction, wheel delta and the three button bits. The
// block takes one byte per clock while no packet-closing byte waits on a
// held result. The last byte of a packet is captured in the input register;
// the decoded word is then loaded into the result register and m_tvalid
// rises. The input register keeps accepting while a result waits to be
// taken, and only a packet-closing byte stalls behind a held result.
// wheel_mode should be changed only while the block is idle.
module ps2_mouse_packet_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] aux_byte
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    // m_tdata: [8:0] delta_x, [18:9] delta_y, [26:19] delta_wheel,
    // [29:27] button_bits, [30] has_wheel, [31] zero
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [ps2md_pkg::TDATA_W-1:0] m_tdata,
    // cfg_data: wheel_mode
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_data
);
    import ps2md_pkg::*;

    `include "assert_macros.svh"

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              m_tvalid_reg;
    result_t           result_reg;
    logic              wheel_mode_reg;
    logic              out_free;
    logic              in_advance;
    logic              frame_complete;
    result_t           frame_result;

    assign cfg_ready  = 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_advance = !frame_complete || out_free;
    assign s_tready   = !in_valid_reg || in_advance;

    ps2md_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_byte    (in_byte_reg),
        .advance    (in_advance),
        .wheel_mode (wheel_mode_reg),
        .complete   (frame_complete),
        .result     (frame_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            wheel_mode_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (frame_complete && in_advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                wheel_mode_reg <= cfg_data;
            end
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (frame_complete && in_advance) begin
            result_reg <= frame_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, result_reg};

    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !in_valid_reg && !m_tvalid_reg, "valid not cleared by reset")
    `ASSERT_CLK(a_no_overwrite, m_tvalid_reg && !m_tready |-> !(frame_complete && in_advance), "held result overwritten")
    `ASSERT_CLK(a_result_issued, frame_complete && in_advance |=> m_tvalid_reg, "closed packet gave no result")

endmodule

`default_nettype wire

### sim/ps2_mouse_packet_decoder_tb.sv
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_tb;
    import ps2md_pkg::*;

    localparam int STD_LEN       = 3;
    localparam int WHEEL_LEN     = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_BYTES  = 480;
    localparam int PHASES        = 6;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // Bytes waiting to be offered, and decoded moves waiting to come out.
    logic [7:0] mouse_bytes[$];
    result_t    pending_moves[$];
    int unsigned bytes_sent = 0;
    int unsigned bytes_taken = 0;

    // Shadow of the decoder state.
    logic [7:0] gathered[0:2] = '{8'h00, 8'h00, 8'h00};
    logic [2:0] gathered_cnt = 3'd0;
    logic       wheel_on = 1'b0;

    int unsigned gap_pct = 35;
    logic        hold_sender = 1'b0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;

    ps2_mouse_packet_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Feeds one accepted mouse byte through the shadow state and queues the
    // decoded move when the byte closes a packet.
    task automatic decode_byte(input logic [7:0] b);
        int         cnt;
        int         need;
        logic [7:0] pk[0:3];
        logic [7:0] hdr;
        logic [9:0] y_ext;
        result_t    mv;
        cnt  = gathered_cnt;
        need = wheel_on ? WHEEL_LEN : STD_LEN;
        if (cnt == 0 && !b[HDR_SYNC_BIT])
            return;
        if (cnt + 1 < need) begin
            if (cnt < 3)
                gathered[cnt] = b;
            gathered_cnt = 3'(cnt + 1);
            return;
        end
        pk[0] = gathered[0];
        pk[1] = gathered[1];
        pk[2] = gathered[2];
        pk[3] = 8'h00;
        // A byte past the end of a shortened packet only closes it.
        if (cnt < 4)
            pk[cnt] = b;
        hdr = pk[0];
        y_ext = {hdr[HDR_YSIGN_BIT], hdr[HDR_YSIGN_BIT], pk[2]};
        mv.delta_x     = {hdr[HDR_XSIGN_BIT], pk[1]};
        mv.delta_y     = 10'd0 - y_ext;
        mv.delta_wheel = (need == WHEEL_LEN) ? pk[3] : 8'h00;
        mv.button_bits = hdr[BTN_W-1:0];
        mv.has_wheel   = (need == WHEEL_LEN);
        pending_moves.push_back(mv);
        gathered_cnt = 3'd0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        mouse_bytes.push_back(b);
        bytes_sent++;
    endtask

    // Waits until every byte is taken and every move has come out, then lets
    // the pipeline run empty.
    task automatic settle();
        while (bytes_taken != bytes_sent || pending_moves.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_wheel_mode(input logic mode);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        wheel_on = mode;
    endtask

    // Mostly well-formed packets with random content; the rest is stray
    // bytes, some of which knock the framing out of step.
    task automatic fill_random(input int n, input logic wheel);
        int count;
        int pick;
        int k;
        count = 0;
        while (count < n) begin
            if ($urandom_range(99) < 12) begin
                push_byte(8'($urandom));
                count++;
            end else begin
                push_byte(8'($urandom) | 8'h08);
                for (k = 0; k < (wheel ? WHEEL_LEN - 1 : STD_LEN - 1); k++) begin
                    pick = $urandom_range(99);
                    push_byte(pick < 10 ? 8'h00 : pick < 20 ? 8'hFF : 8'($urandom));
                end
                count += wheel ? WHEEL_LEN : STD_LEN;
            end
        end
    endtask

    // Sender: keeps a word steady until it is taken, then loads the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (mouse_bytes.size() != 0 && !hold_sender
                        && $urandom_range(99) >= gap_pct) begin
                    s_tdata  <= mouse_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= gap_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (pending_moves.size() == 0) begin
                report_mismatch($sformatf("unexpected move x=%0d y=%0d w=%0d btn=%0d hw=%0d",
                    got.delta_x, got.delta_y, got.delta_wheel, got.button_bits,
                    got.has_wheel));
            end else begin
                want = pending_moves.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "x=%0d/%0d y=%0d/%0d w=%0d/%0d btn=%0d/%0d hw=%0d/%0d (got/exp)",
                        got.delta_x, want.delta_x, got.delta_y, want.delta_y,
                        got.delta_wheel, want.delta_wheel, got.button_bits,
                        want.button_bits, got.has_wheel, want.has_wheel));
            end
        end
    end

    // Watchdog on handshake progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        logic mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_wheel_mode(1'b0);

        // Bytes without the sync bit are dropped at the start of a packet.
        push_byte(8'h00);
        push_byte(8'hF7);
        // Zero move, then the most negative X and the largest Y with all buttons.
        push_byte(8'h08); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h3F); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h08); push_byte(8'hFF); push_byte(8'hFF);
        // Overflow bits are ignored.
        push_byte(8'hC8); push_byte(8'h80); push_byte(8'h80);
        // Switch to wheel packets with two bytes already gathered.
        push_byte(8'h08); push_byte(8'h7F);
        write_wheel_mode(1'b1);
        push_byte(8'h80); push_byte(8'h7F);
        push_byte(8'h29); push_byte(8'h12); push_byte(8'h34); push_byte(8'h80);
        // Back to short packets with three bytes gathered: the next byte
        // closes the packet and is thrown away.
        push_byte(8'h0A); push_byte(8'h01); push_byte(8'h02);
        write_wheel_mode(1'b0);
        push_byte(8'h55);

        for (ph = 0; ph < PHASES; ph++) begin
            mode = 1'($urandom_range(1));
            write_wheel_mode(mode);
            gap_pct = (ph == 2) ? 0 : 35;
            fill_random(RANDOM_BYTES / PHASES, mode);
            if (ph == 3) begin
                while (bytes_taken < bytes_sent - 40)
                    @(posedge aclk);
                hold_sender <= 1'b1;
                @(posedge aclk);
                while (pending_moves.size() != 0)
                    @(posedge aclk);
                hold_sender <= 1'b0;
            end
        end

        settle();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/ps2md_pkg.sv
hdl/ps2md_frame.sv
hdl/ps2_mouse_packet_decoder.sv
sim/ps2_mouse_packet_decoder_tb.sv
